[rtl/pcw_pkg.sv]
// ----------------------------------------------------------------------------
// pcw_pkg: shared types and constants for the periodic cell wrap block
// Fixed-point formats, register map and the sideband that travels with
// every item through the pipeline.
// ----------------------------------------------------------------------------
package pcw_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 21;
  localparam int TAG_WIDTH   = 16;
  localparam int NUM_AXES    = 3;

  localparam int COORD_FRAC = COORD_WIDTH / 2;
  localparam int INV_FRAC   = COEF_WIDTH - 1;
  localparam int CELL_FRAC  = (COEF_WIDTH - 1) / 2;
  localparam int S_FRAC     = COORD_FRAC + INV_FRAC;
  localparam int BACK_SHIFT = S_FRAC + CELL_FRAC - COORD_FRAC;

  // Forward map widths.
  localparam int FWD_PROD_WIDTH = COEF_WIDTH + COORD_WIDTH;
  localparam int FWD_SUM_WIDTH  = FWD_PROD_WIDTH + 2;
  localparam int SCALED_WIDTH   = FWD_SUM_WIDTH + 1;

  // Back map: the scaled value is split into an unsigned low half and a
  // signed high half so that each multiplier stays narrow.
  localparam int S_LO_WIDTH      = SCALED_WIDTH / 2;
  localparam int S_HI_WIDTH      = SCALED_WIDTH - S_LO_WIDTH;
  localparam int LO_PROD_WIDTH   = COEF_WIDTH + S_LO_WIDTH + 1;
  localparam int HI_PROD_WIDTH   = COEF_WIDTH + S_HI_WIDTH;
  localparam int BACK_PROD_WIDTH = COEF_WIDTH + SCALED_WIDTH;
  localparam int BACK_SUM_WIDTH  = BACK_PROD_WIDTH + 2;
  localparam int SHIFTED_WIDTH   = BACK_SUM_WIDTH - BACK_SHIFT;

  // Register map.
  localparam int REG_WIDTH     = 3 * COEF_WIDTH;
  localparam int NUM_REGS      = 6;
  localparam int PADDR_WIDTH   = 6;
  localparam int PDATA_WIDTH   = 64;
  localparam int REG_ADDR_LSB  = 3;
  localparam int REG_IDX_WIDTH = PADDR_WIDTH - REG_ADDR_LSB;

  localparam logic [REG_IDX_WIDTH-1:0] REG_CELL_A = REG_IDX_WIDTH'(0);
  localparam logic [REG_IDX_WIDTH-1:0] REG_CELL_B = REG_IDX_WIDTH'(1);
  localparam logic [REG_IDX_WIDTH-1:0] REG_CELL_C = REG_IDX_WIDTH'(2);
  localparam logic [REG_IDX_WIDTH-1:0] REG_INV_A  = REG_IDX_WIDTH'(3);
  localparam logic [REG_IDX_WIDTH-1:0] REG_INV_B  = REG_IDX_WIDTH'(4);
  localparam logic [REG_IDX_WIDTH-1:0] REG_INV_C  = REG_IDX_WIDTH'(5);

  localparam logic signed [SCALED_WIDTH-1:0] S_ONE  = SCALED_WIDTH'(64'sd1 <<< S_FRAC);
  localparam logic signed [SCALED_WIDTH-1:0] S_HALF = S_ONE >>> 1;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam logic MODE_POSITION     = 1'b0;
  localparam logic MODE_DISPLACEMENT = 1'b1;

  typedef logic [REG_WIDTH-1:0]             reg_word_t;
  typedef logic [2:0][REG_WIDTH-1:0]        row_set_t;
  typedef logic signed [COORD_WIDTH-1:0]    coord_t;
  typedef logic signed [SCALED_WIDTH-1:0]   scaled_t;

  typedef struct packed {
    logic                 mode;
    logic [TAG_WIDTH-1:0] tag;
  } side_t;

  // Component k of a packed register word, two's complement.
  function automatic logic signed [COEF_WIDTH-1:0] coef(input reg_word_t word, input int k);
    return word[k*COEF_WIDTH +: COEF_WIDTH];
  endfunction

endpackage

[rtl/pcw_regs.sv]
// ----------------------------------------------------------------------------
// pcw_regs: configuration register file
// Six 63-bit matrix rows on an APB-style port, 64-bit data, 8-byte stride.
// ----------------------------------------------------------------------------
module pcw_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcw_pkg::PADDR_WIDTH-1:0]     paddr,
  input  logic [pcw_pkg::PDATA_WIDTH-1:0]     pwdata,
  output logic [pcw_pkg::PDATA_WIDTH-1:0]     prdata,
  output logic                                pready,
  output pcw_pkg::row_set_t                   cell_rows,
  output pcw_pkg::row_set_t                   inv_rows
);

  pcw_pkg::reg_word_t                      regs [pcw_pkg::NUM_REGS];
  logic [pcw_pkg::REG_IDX_WIDTH-1:0]       idx;
  logic                                    idx_ok;
  logic                                    wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[pcw_pkg::PADDR_WIDTH-1:pcw_pkg::REG_ADDR_LSB];
  assign idx_ok = (idx <= pcw_pkg::REG_INV_C);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcw_pkg::NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (wr_en && idx_ok) begin
      regs[idx] <= pwdata[pcw_pkg::REG_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = pcw_pkg::PDATA_WIDTH'(regs[idx]);
    end
  end

  assign cell_rows[0] = regs[pcw_pkg::REG_CELL_A];
  assign cell_rows[1] = regs[pcw_pkg::REG_CELL_B];
  assign cell_rows[2] = regs[pcw_pkg::REG_CELL_C];
  assign inv_rows[0]  = regs[pcw_pkg::REG_INV_A];
  assign inv_rows[1]  = regs[pcw_pkg::REG_INV_B];
  assign inv_rows[2]  = regs[pcw_pkg::REG_INV_C];

endmodule

[rtl/pcw_fwd.sv]
// ----------------------------------------------------------------------------
// pcw_fwd: forward map into scaled cell coordinates and single wrap
// Three stages: nine products, three sums, then the one-cell wrap.
// ----------------------------------------------------------------------------
module pcw_fwd (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcw_pkg::coord_t    in_vec [pcw_pkg::NUM_AXES],
  input  pcw_pkg::side_t     in_side,
  input  pcw_pkg::row_set_t  inv_rows,
  output logic               out_valid,
  input  logic               out_ready,
  output pcw_pkg::scaled_t   out_scaled [pcw_pkg::NUM_AXES],
  output pcw_pkg::side_t     out_side
);

  logic                                          va, vb, vc;
  logic                                          ra, rb, rc;
  logic signed [pcw_pkg::FWD_PROD_WIDTH-1:0]     pa [pcw_pkg::NUM_AXES][pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::FWD_PROD_WIDTH-1:0]     pa_next [pcw_pkg::NUM_AXES][pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::FWD_SUM_WIDTH-1:0]      sb [pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::FWD_SUM_WIDTH-1:0]      sb_next [pcw_pkg::NUM_AXES];
  pcw_pkg::scaled_t                              sc [pcw_pkg::NUM_AXES];
  pcw_pkg::scaled_t                              sc_next [pcw_pkg::NUM_AXES];
  pcw_pkg::side_t                                side_a, side_b, side_c;

  // A stage can load whenever it is empty or its contents move on.
  assign rc       = !vc || out_ready;
  assign rb       = !vb || rc;
  assign ra       = !va || rb;
  assign in_ready = ra;

  always_comb begin
    for (int k = 0; k < pcw_pkg::NUM_AXES; k++) begin
      for (int j = 0; j < pcw_pkg::NUM_AXES; j++) begin
        pa_next[k][j] = pcw_pkg::coef(inv_rows[j], k) * in_vec[j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < pcw_pkg::NUM_AXES; k++) begin
      sb_next[k] = pa[k][0] + pa[k][1] + pa[k][2];
    end
  end

  // Each component moves by at most one cell, so a far vector stays outside.
  always_comb begin
    pcw_pkg::scaled_t se;
    for (int k = 0; k < pcw_pkg::NUM_AXES; k++) begin
      se = sb[k];
      sc_next[k] = se;
      if (side_b.mode == pcw_pkg::MODE_POSITION) begin
        if (se >= pcw_pkg::S_ONE) begin
          sc_next[k] = se - pcw_pkg::S_ONE;
        end else if (se < 0) begin
          sc_next[k] = se + pcw_pkg::S_ONE;
        end
      end else begin
        if (se >= pcw_pkg::S_HALF) begin
          sc_next[k] = se - pcw_pkg::S_ONE;
        end else if (se < -pcw_pkg::S_HALF) begin
          sc_next[k] = se + pcw_pkg::S_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ra) begin
        va <= in_valid;
      end
      if (rb) begin
        vb <= va;
      end
      if (rc) begin
        vc <= vb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ra && in_valid) begin
      pa     <= pa_next;
      side_a <= in_side;
    end
    if (rb && va) begin
      sb     <= sb_next;
      side_b <= side_a;
    end
    if (rc && vb) begin
      sc     <= sc_next;
      side_c <= side_b;
    end
  end

  assign out_valid  = vc;
  assign out_scaled = sc;
  assign out_side   = side_c;

  // A stalled wrap result must hold until the back map takes it.
  a_wrap_hold: assert property (@(posedge clk) disable iff (rst)
    vc && !out_ready |=> vc && $stable(sc[0]) && $stable(sc[1]) && $stable(sc[2])
      && $stable(side_c))
    else $error("wrap stage changed while stalled");

endmodule

[rtl/pcw_back.sv]
// ----------------------------------------------------------------------------
// pcw_back: map back to Angstrom with the cell matrix, then saturate
// Four stages: split partial products, product merge, three sums, and the
// output register with floor shift and saturation.
// ----------------------------------------------------------------------------
module pcw_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcw_pkg::scaled_t   in_scaled [pcw_pkg::NUM_AXES],
  input  pcw_pkg::side_t     in_side,
  input  pcw_pkg::row_set_t  cell_rows,
  output logic               out_valid,
  input  logic               out_ready,
  output pcw_pkg::coord_t    out_coord [pcw_pkg::NUM_AXES],
  output pcw_pkg::side_t     out_side
);

  logic                                          vd, ve, vf, vg;
  logic                                          rd, re, rf, rg;
  logic signed [pcw_pkg::LO_PROD_WIDTH-1:0]      lo_d [pcw_pkg::NUM_AXES][pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::LO_PROD_WIDTH-1:0]      lo_next [pcw_pkg::NUM_AXES][pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::HI_PROD_WIDTH-1:0]      hi_d [pcw_pkg::NUM_AXES][pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::HI_PROD_WIDTH-1:0]      hi_next [pcw_pkg::NUM_AXES][pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::BACK_PROD_WIDTH-1:0]    pe [pcw_pkg::NUM_AXES][pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::BACK_PROD_WIDTH-1:0]    pe_next [pcw_pkg::NUM_AXES][pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::BACK_SUM_WIDTH-1:0]     sf [pcw_pkg::NUM_AXES];
  logic signed [pcw_pkg::BACK_SUM_WIDTH-1:0]     sf_next [pcw_pkg::NUM_AXES];
  pcw_pkg::coord_t                               og [pcw_pkg::NUM_AXES];
  pcw_pkg::coord_t                               og_next [pcw_pkg::NUM_AXES];
  pcw_pkg::side_t                                side_d, side_e, side_f, side_g;

  assign rg       = !vg || out_ready;
  assign rf       = !vf || rg;
  assign re       = !ve || rf;
  assign rd       = !vd || re;
  assign in_ready = rd;

  // The low half is taken as unsigned, the high half carries the sign.
  always_comb begin
    for (int k = 0; k < pcw_pkg::NUM_AXES; k++) begin
      for (int j = 0; j < pcw_pkg::NUM_AXES; j++) begin
        lo_next[k][j] = pcw_pkg::coef(cell_rows[j], k)
                        * $signed({1'b0, in_scaled[j][pcw_pkg::S_LO_WIDTH-1:0]});
        hi_next[k][j] = pcw_pkg::coef(cell_rows[j], k)
                        * $signed(in_scaled[j][pcw_pkg::SCALED_WIDTH-1:pcw_pkg::S_LO_WIDTH]);
      end
    end
  end

  always_comb begin
    logic signed [pcw_pkg::BACK_PROD_WIDTH-1:0] lo_ext;
    logic signed [pcw_pkg::BACK_PROD_WIDTH-1:0] hi_ext;
    for (int k = 0; k < pcw_pkg::NUM_AXES; k++) begin
      for (int j = 0; j < pcw_pkg::NUM_AXES; j++) begin
        lo_ext = lo_d[k][j];
        hi_ext = hi_d[k][j];
        pe_next[k][j] = (hi_ext <<< pcw_pkg::S_LO_WIDTH) + lo_ext;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < pcw_pkg::NUM_AXES; k++) begin
      sf_next[k] = pe[k][0] + pe[k][1] + pe[k][2];
    end
  end

  // Floor to the coordinate fraction, then clamp when the upper bits are
  // not a pure sign extension.
  always_comb begin
    logic signed [pcw_pkg::SHIFTED_WIDTH-1:0] sh;
    logic [pcw_pkg::SHIFTED_WIDTH-pcw_pkg::COORD_WIDTH:0] top;
    for (int k = 0; k < pcw_pkg::NUM_AXES; k++) begin
      sh  = sf[k][pcw_pkg::BACK_SUM_WIDTH-1:pcw_pkg::BACK_SHIFT];
      top = sh[pcw_pkg::SHIFTED_WIDTH-1:pcw_pkg::COORD_WIDTH-1];
      if (top == '0 || top == '1) begin
        og_next[k] = sh[pcw_pkg::COORD_WIDTH-1:0];
      end else if (sh[pcw_pkg::SHIFTED_WIDTH-1]) begin
        og_next[k] = pcw_pkg::COORD_MIN;
      end else begin
        og_next[k] = pcw_pkg::COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
    end else begin
      if (rd) begin
        vd <= in_valid;
      end
      if (re) begin
        ve <= vd;
      end
      if (rf) begin
        vf <= ve;
      end
      if (rg) begin
        vg <= vf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd && in_valid) begin
      lo_d   <= lo_next;
      hi_d   <= hi_next;
      side_d <= in_side;
    end
    if (re && vd) begin
      pe     <= pe_next;
      side_e <= side_d;
    end
    if (rf && ve) begin
      sf     <= sf_next;
      side_f <= side_e;
    end
    if (rg && vf) begin
      og     <= og_next;
      side_g <= side_f;
    end
  end

  assign out_valid = vg;
  assign out_coord = og;
  assign out_side  = side_g;

  a_reset_empty: assert property (@(posedge clk) rst |=> !vg && !vf && !ve && !vd)
    else $error("back map pipeline not empty after reset");

  // The output stage only loads from a valid sum stage.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !vg && !vf |=> !vg)
    else $error("result appeared without a source item");

endmodule

[rtl/periodic_cell_wrap.sv]
// ----------------------------------------------------------------------------
// periodic_cell_wrap: triclinic minimum-image wrap of a fixed-point 3-vector
//
//   channel   handshake                          payload
//   -------   ---------------------------------  ------------------------------
//   input     in_valid / in_ready                mode, vec_x, vec_y, vec_z, tag
//   output    out_valid / out_ready              out_x, out_y, out_z, out_tag,
//                                                out_mode
//   config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// Seven register stages (three forward, four back); one item is taken every
// cycle unless back-pressure from out_ready has filled the pipeline.
// The depth is set by the split 21x56 back-map multipliers and their merge.
// Each stage loads when empty or draining, so bubbles close up under stall.
// Synchronous reset empties the pipeline and clears all matrix registers.
// ----------------------------------------------------------------------------
module periodic_cell_wrap (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pcw_pkg::PADDR_WIDTH-1:0]  paddr,
  input  logic [pcw_pkg::PDATA_WIDTH-1:0]  pwdata,
  output logic [pcw_pkg::PDATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic signed [pcw_pkg::COORD_WIDTH-1:0] vec_x,
  input  logic signed [pcw_pkg::COORD_WIDTH-1:0] vec_y,
  input  logic signed [pcw_pkg::COORD_WIDTH-1:0] vec_z,
  input  logic [pcw_pkg::TAG_WIDTH-1:0]    tag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [pcw_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [pcw_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [pcw_pkg::COORD_WIDTH-1:0] out_z,
  output logic [pcw_pkg::TAG_WIDTH-1:0]    out_tag,
  output logic                             out_mode
);

  pcw_pkg::row_set_t   cell_rows;
  pcw_pkg::row_set_t   inv_rows;
  pcw_pkg::coord_t     vec [pcw_pkg::NUM_AXES];
  pcw_pkg::side_t      side_in;
  logic                mid_valid;
  logic                mid_ready;
  pcw_pkg::scaled_t    mid_scaled [pcw_pkg::NUM_AXES];
  pcw_pkg::side_t      mid_side;
  pcw_pkg::coord_t     coord [pcw_pkg::NUM_AXES];
  pcw_pkg::side_t      side_out;

  assign vec[0]       = vec_x;
  assign vec[1]       = vec_y;
  assign vec[2]       = vec_z;
  assign side_in.mode = mode;
  assign side_in.tag  = tag;

  pcw_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cell_rows (cell_rows),
    .inv_rows  (inv_rows)
  );

  pcw_fwd u_fwd (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_vec     (vec),
    .in_side    (side_in),
    .inv_rows   (inv_rows),
    .out_valid  (mid_valid),
    .out_ready  (mid_ready),
    .out_scaled (mid_scaled),
    .out_side   (mid_side)
  );

  pcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_scaled (mid_scaled),
    .in_side   (mid_side),
    .cell_rows (cell_rows),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_coord (coord),
    .out_side  (side_out)
  );

  assign out_x    = coord[0];
  assign out_y    = coord[1];
  assign out_z    = coord[2];
  assign out_tag  = side_out.tag;
  assign out_mode = side_out.mode;

  // With the output register empty every stage can move, so input is open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output register is empty");

endmodule

[dv/tb_periodic_cell_wrap.sv]
// ----------------------------------------------------------------------------
// tb_periodic_cell_wrap: self-checking bench for the periodic cell wrap block
// Starts with all-zero registers, then loads cell matrices over APB: cubic cells,
// skewed cells, saturating extremes and raw random words. It then streams
// position and displacement vectors through the block. A bit-exact model of
// the fixed-point wrap predicts every result, and each returned item is
// compared field by field in order. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_periodic_cell_wrap;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 12;
  localparam logic [pcw_pkg::COEF_WIDTH-1:0] COEF_MAX =
    {1'b0, {(pcw_pkg::COEF_WIDTH-1){1'b1}}};
  localparam logic [pcw_pkg::COEF_WIDTH-1:0] COEF_MIN =
    {1'b1, {(pcw_pkg::COEF_WIDTH-1){1'b0}}};
  localparam int ANGSTROM = 1 << pcw_pkg::COORD_FRAC;

  typedef struct {
    logic                          mode;
    pcw_pkg::coord_t               x;
    pcw_pkg::coord_t               y;
    pcw_pkg::coord_t               z;
    logic [pcw_pkg::TAG_WIDTH-1:0] tag;
    bit                            wait_drain;
  } vector_t;

  typedef struct {
    pcw_pkg::coord_t               x;
    pcw_pkg::coord_t               y;
    pcw_pkg::coord_t               z;
    logic [pcw_pkg::TAG_WIDTH-1:0] tag;
    logic                          mode;
  } wrapped_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [pcw_pkg::PADDR_WIDTH-1:0] paddr = '0;
  logic [pcw_pkg::PDATA_WIDTH-1:0] pwdata = '0;
  logic [pcw_pkg::PDATA_WIDTH-1:0] prdata;
  logic                            pready;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            mode = 1'b0;
  pcw_pkg::coord_t                 vec_x = '0;
  pcw_pkg::coord_t                 vec_y = '0;
  pcw_pkg::coord_t                 vec_z = '0;
  logic [pcw_pkg::TAG_WIDTH-1:0]   tag = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  pcw_pkg::coord_t                 out_x;
  pcw_pkg::coord_t                 out_y;
  pcw_pkg::coord_t                 out_z;
  logic [pcw_pkg::TAG_WIDTH-1:0]   out_tag;
  logic                            out_mode;

  pcw_pkg::reg_word_t reg_shadow [pcw_pkg::NUM_REGS] = '{default: '0};
  vector_t   vector_q [$];
  wrapped_t  wrapped_q [$];
  vector_t   next_vec;
  vector_t   taken_vec;
  wrapped_t  want;
  logic      vec_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        error_count = 0;
  int        results_checked = 0;
  int        settings_used = 0;

  periodic_cell_wrap dut (.*);

  always #1 clk = ~clk;

  // Bit-exact wrap of one vector with the current register contents.
  function automatic wrapped_t wrap_vector(input vector_t v);
    logic signed [127:0]                   r [pcw_pkg::NUM_AXES];
    logic signed [127:0]                   s [pcw_pkg::NUM_AXES];
    logic signed [127:0]                   acc, coef_w, one, half, hi_lim, lo_lim;
    logic signed [pcw_pkg::COEF_WIDTH-1:0] c;
    pcw_pkg::coord_t                       res [pcw_pkg::NUM_AXES];
    wrapped_t                              w;
    r[0] = v.x;
    r[1] = v.y;
    r[2] = v.z;
    one = 128'sd1 <<< pcw_pkg::S_FRAC;
    half = one >>> 1;
    hi_lim = pcw_pkg::COORD_MAX;
    lo_lim = pcw_pkg::COORD_MIN;
    // The forward sums keep every fraction bit and fit the 55-bit sum width,
    // so no rounding or clamping is needed here.
    for (int k = 0; k < pcw_pkg::NUM_AXES; k++) begin
      acc = '0;
      for (int j = 0; j < pcw_pkg::NUM_AXES; j++) begin
        c = reg_shadow[pcw_pkg::REG_INV_A + j][k*pcw_pkg::COEF_WIDTH +: pcw_pkg::COEF_WIDTH];
        coef_w = c;
        acc = acc + coef_w * r[j];
      end
      // A single shift by one cell: far vectors stay outside.
      if (v.mode == pcw_pkg::MODE_POSITION) begin
        if (acc >= one) acc = acc - one;
        if (acc < 0) acc = acc + one;
      end else begin
        if (acc >= half) acc = acc - one;
        if (acc < -half) acc = acc + one;
      end
      s[k] = acc;
    end
    for (int k = 0; k < pcw_pkg::NUM_AXES; k++) begin
      acc = '0;
      for (int j = 0; j < pcw_pkg::NUM_AXES; j++) begin
        c = reg_shadow[pcw_pkg::REG_CELL_A + j][k*pcw_pkg::COEF_WIDTH +: pcw_pkg::COEF_WIDTH];
        coef_w = c;
        acc = acc + coef_w * s[j];
      end
      acc = acc >>> pcw_pkg::BACK_SHIFT;
      if (acc > hi_lim) res[k] = pcw_pkg::COORD_MAX;
      else if (acc < lo_lim) res[k] = pcw_pkg::COORD_MIN;
      else res[k] = acc[pcw_pkg::COORD_WIDTH-1:0];
    end
    w.x = res[0];
    w.y = res[1];
    w.z = res[2];
    w.tag = v.tag;
    w.mode = v.mode;
    return w;
  endfunction

  function automatic void check_field(input string name, input longint want_v,
                                      input longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      error_count++;
    end
  endfunction

  function automatic pcw_pkg::reg_word_t pack_row(
      input logic [pcw_pkg::COEF_WIDTH-1:0] c0, c1, c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [pcw_pkg::COEF_WIDTH-1:0] to_coef(input real v, input int frac);
    real scaled;
    int  q;
    scaled = v * (1 << frac);
    q = $rtoi(scaled >= 0.0 ? scaled + 0.5 : scaled - 0.5);
    if (q > (1 << (pcw_pkg::COEF_WIDTH - 1)) - 1) q = (1 << (pcw_pkg::COEF_WIDTH - 1)) - 1;
    if (q < -(1 << (pcw_pkg::COEF_WIDTH - 1))) q = -(1 << (pcw_pkg::COEF_WIDTH - 1));
    return pcw_pkg::COEF_WIDTH'(q);
  endfunction

  function automatic pcw_pkg::coord_t rand_coord(input int span);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return pcw_pkg::coord_t'($urandom);
    if (pick == 1) return pcw_pkg::coord_t'(int'($urandom_range(0, 32)) - 16);
    return pcw_pkg::coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic apb_write(input logic [pcw_pkg::REG_IDX_WIDTH-1:0] idx,
                           input logic [pcw_pkg::PDATA_WIDTH-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pcw_pkg::PADDR_WIDTH'(idx) << pcw_pkg::REG_ADDR_LSB;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_shadow[idx] = value[pcw_pkg::REG_WIDTH-1:0];
  endtask

  task automatic write_matrix(input logic [pcw_pkg::PDATA_WIDTH-1:0] wa, wb, wc, ia, ib, ic);
    apb_write(pcw_pkg::REG_CELL_A, wa);
    apb_write(pcw_pkg::REG_CELL_B, wb);
    apb_write(pcw_pkg::REG_CELL_C, wc);
    apb_write(pcw_pkg::REG_INV_A, ia);
    apb_write(pcw_pkg::REG_INV_B, ib);
    apb_write(pcw_pkg::REG_INV_C, ic);
    settings_used++;
  endtask

  // Cell vectors in Angstrom; the inverse rows are the rows of H^-1, whose
  // columns are the cross products of the cell vectors over the volume.
  task automatic load_cell(input real ax, ay, az, bx, by, bz, cx, cy, cz);
    real                bc [3];
    real                ca [3];
    real                ab [3];
    real                det;
    pcw_pkg::reg_word_t inv_row [3];
    bc[0] = by*cz - bz*cy; bc[1] = bz*cx - bx*cz; bc[2] = bx*cy - by*cx;
    ca[0] = cy*az - cz*ay; ca[1] = cz*ax - cx*az; ca[2] = cx*ay - cy*ax;
    ab[0] = ay*bz - az*by; ab[1] = az*bx - ax*bz; ab[2] = ax*by - ay*bx;
    det = ax*bc[0] + ay*bc[1] + az*bc[2];
    for (int j = 0; j < 3; j++) begin
      inv_row[j] = pack_row(to_coef(bc[j] / det, pcw_pkg::INV_FRAC),
                            to_coef(ca[j] / det, pcw_pkg::INV_FRAC),
                            to_coef(ab[j] / det, pcw_pkg::INV_FRAC));
    end
    write_matrix(pack_row(to_coef(ax, pcw_pkg::CELL_FRAC), to_coef(ay, pcw_pkg::CELL_FRAC),
                          to_coef(az, pcw_pkg::CELL_FRAC)),
                 pack_row(to_coef(bx, pcw_pkg::CELL_FRAC), to_coef(by, pcw_pkg::CELL_FRAC),
                          to_coef(bz, pcw_pkg::CELL_FRAC)),
                 pack_row(to_coef(cx, pcw_pkg::CELL_FRAC), to_coef(cy, pcw_pkg::CELL_FRAC),
                          to_coef(cz, pcw_pkg::CELL_FRAC)),
                 inv_row[0], inv_row[1], inv_row[2]);
  endtask

  task automatic load_uniform(input logic [pcw_pkg::COEF_WIDTH-1:0] box_c, inv_c);
    write_matrix(pack_row(box_c, box_c, box_c), pack_row(box_c, box_c, box_c),
                 pack_row(box_c, box_c, box_c), pack_row(inv_c, inv_c, inv_c),
                 pack_row(inv_c, inv_c, inv_c), pack_row(inv_c, inv_c, inv_c));
  endtask

  task automatic push_vector(input logic m, input pcw_pkg::coord_t x, y, z,
                             input logic [pcw_pkg::TAG_WIDTH-1:0] t,
                             input bit drain = 1'b0);
    vector_t v;
    v.mode = m;
    v.x = x;
    v.y = y;
    v.z = z;
    v.tag = t;
    v.wait_drain = drain;
    vector_q.push_back(v);
  endtask

  task automatic push_random(input int count, input int span);
    for (int i = 0; i < count; i++) begin
      push_vector($urandom_range(0, 1) ? pcw_pkg::MODE_DISPLACEMENT : pcw_pkg::MODE_POSITION,
                  rand_coord(span), rand_coord(span), rand_coord(span),
                  pcw_pkg::TAG_WIDTH'($urandom), $urandom_range(0, 79) == 0);
    end
  endtask

  task automatic wait_drained();
    while (vector_q.size() != 0 || in_valid || wrapped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Input driver: a new item goes out only once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || vec_taken) begin
      if (vector_q.size() != 0 && (!vector_q[0].wait_drain || wrapped_q.size() == 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        next_vec = vector_q.pop_front();
        in_valid <= 1'b1;
        mode <= next_vec.mode;
        vec_x <= next_vec.x;
        vec_y <= next_vec.y;
        vec_z <= next_vec.z;
        tag <= next_vec.tag;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      vec_taken <= 1'b0;
    end else begin
      vec_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        taken_vec.mode = mode;
        taken_vec.x = vec_x;
        taken_vec.y = vec_y;
        taken_vec.z = vec_z;
        taken_vec.tag = tag;
        taken_vec.wait_drain = 1'b0;
        wrapped_q.push_back(wrap_vector(taken_vec));
      end
      if (out_valid && out_ready) begin
        if (wrapped_q.size() == 0) begin
          $error("result with no item outstanding: out_tag %0h", out_tag);
          error_count++;
        end else begin
          want = wrapped_q.pop_front();
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_z", want.z, out_z);
          check_field("out_tag", want.tag, out_tag);
          check_field("out_mode", want.mode, out_mode);
          results_checked++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 6;
    recv_stall_pct = 45;

    // Registers still at reset: every vector collapses to the origin.
    push_vector(pcw_pkg::MODE_POSITION, pcw_pkg::COORD_MAX, -32'sd1, 32'sh0123_4567,
                16'h0001);
    push_vector(pcw_pkg::MODE_DISPLACEMENT, pcw_pkg::COORD_MIN, 32'sd1, -32'sh0123_4567,
                16'h8000);
    wait_drained();

    // A 16 Angstrom cube has an exact inverse, so the wrap edges land exactly.
    load_cell(16.0, 0.0, 0.0, 0.0, 16.0, 0.0, 0.0, 0.0, 16.0);
    push_vector(pcw_pkg::MODE_POSITION, 0, 0, 0, 16'h0000);
    push_vector(pcw_pkg::MODE_POSITION, 16 * ANGSTROM, 8 * ANGSTROM, -32'sd1, 16'hFFFF);
    push_vector(pcw_pkg::MODE_DISPLACEMENT, 8 * ANGSTROM, -8 * ANGSTROM, 8 * ANGSTROM - 1,
                16'h0102);
    push_vector(pcw_pkg::MODE_DISPLACEMENT, 16 * ANGSTROM, -16 * ANGSTROM, 24 * ANGSTROM,
                16'h0203);
    // Far outside the cell: only one cell is removed.
    push_vector(pcw_pkg::MODE_POSITION, 32 * ANGSTROM, -20 * ANGSTROM, 48 * ANGSTROM,
                16'h0304);
    push_vector(pcw_pkg::MODE_DISPLACEMENT, 40 * ANGSTROM, -40 * ANGSTROM, 0, 16'h0405);
    push_vector(pcw_pkg::MODE_POSITION, pcw_pkg::COORD_MAX, pcw_pkg::COORD_MIN,
                pcw_pkg::COORD_MAX, 16'h5555);
    push_vector(pcw_pkg::MODE_DISPLACEMENT, pcw_pkg::COORD_MIN, pcw_pkg::COORD_MAX,
                pcw_pkg::COORD_MIN, 16'hAAAA);
    push_vector(pcw_pkg::MODE_POSITION, 1, -1, 32'sh0000_FFFF, 16'h7FFF);
    push_random(100, 48 * ANGSTROM);
    wait_drained();

    load_cell(10.5, 0.0, 0.0, 3.25, 12.75, 0.0, -2.125, 1.5, 15.875);
    push_vector(pcw_pkg::MODE_DISPLACEMENT, 5 * ANGSTROM, -7 * ANGSTROM, 9 * ANGSTROM,
                16'h1234, 1'b1);
    push_random(100, 45 * ANGSTROM);
    wait_drained();

    send_idle_pct = 45;
    recv_stall_pct = 6;
    // Largest coefficients everywhere: results run into the coordinate limits.
    load_uniform(COEF_MAX, COEF_MAX);
    push_vector(pcw_pkg::MODE_POSITION, pcw_pkg::COORD_MAX, pcw_pkg::COORD_MAX,
                pcw_pkg::COORD_MAX, 16'h0F0F);
    push_vector(pcw_pkg::MODE_DISPLACEMENT, pcw_pkg::COORD_MIN, pcw_pkg::COORD_MIN,
                pcw_pkg::COORD_MIN, 16'hF0F0);
    push_vector(pcw_pkg::MODE_POSITION, pcw_pkg::COORD_MAX, pcw_pkg::COORD_MIN, 0, 16'h3C3C);
    push_random(50, 1 << 29);
    wait_drained();

    load_uniform(COEF_MIN, COEF_MIN);
    push_vector(pcw_pkg::MODE_POSITION, pcw_pkg::COORD_MAX, pcw_pkg::COORD_MAX,
                pcw_pkg::COORD_MAX, 16'hC3C3);
    push_vector(pcw_pkg::MODE_DISPLACEMENT, pcw_pkg::COORD_MIN, pcw_pkg::COORD_MIN,
                pcw_pkg::COORD_MIN, 16'h6969);
    push_vector(pcw_pkg::MODE_DISPLACEMENT, pcw_pkg::COORD_MIN, pcw_pkg::COORD_MAX, -32'sd1,
                16'h9696);
    push_random(50, 1 << 29);
    wait_drained();

    load_cell(20.0, 0.0, 0.0, -9.75, 18.0, 0.0, 5.25, -7.125, 25.0);
    push_random(100, 80 * ANGSTROM);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Raw register words, including the unused top bit.
    for (int n = 0; n < 2; n++) begin
      write_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      push_random(50, 1 << 29);
      wait_drained();
    end

    load_cell(3.0, 0.25, -0.5, 0.5, 2.75, 0.125, -0.25, 0.375, 4.0);
    push_random(100, 12 * ANGSTROM);
    wait_drained();

    $display("Checked %0d wrapped vectors under %0d register settings,",
             results_checked, settings_used);
    $display("in both modes with stalls on the input and output sides.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/pcw_pkg.sv
rtl/pcw_regs.sv
rtl/pcw_fwd.sv
rtl/pcw_back.sv
rtl/periodic_cell_wrap.sv
dv/tb_periodic_cell_wrap.sv
